// ===== rtl/selective_ack_window_sender_macros.svh =====
// Assertion macros for the selective-ack window sender.
// Used by the RTL module; no other dependencies.
`ifndef SELECTIVE_ACK_WINDOW_SENDER_MACROS_SVH
`define SELECTIVE_ACK_WINDOW_SENDER_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SAWS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("selective_ack_window_sender: check failed");

// Check that a condition never holds
`define SAWS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `SAWS_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== rtl/saws_pkg.sv =====
// Shared constants for the selective-ack window sender.
// Field widths, command and register codes, reset values; no dependencies.
package saws_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int TYPE_W     = 2;
  localparam int PSEQ_W     = 16;
  localparam int SEND_SEQ_W = 10;
  localparam int WIN_W      = 6;
  localparam int TOTAL_W    = 11;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Storage and clamp limits
  localparam int MAX_PACKETS_DEF = 1024;
  localparam int MAX_WINDOW      = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PACKET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // Packet type of an acknowledgement
  localparam logic [TYPE_W-1:0] PKT_ACK = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  // Configuration reset values
  localparam logic [WIN_W-1:0]     WINDOW_SIZE_RST   = 6'd8;
  localparam logic [TOTAL_W-1:0]   TOTAL_PACKETS_RST = 11'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd500;

endpackage

// ===== rtl/saws_in_if.sv =====
// Input channel of the selective-ack window sender: commands and packets.
// Depends on saws_pkg for field widths.
interface saws_in_if;
  logic                         valid;
  logic                         ready;
  logic [saws_pkg::CMD_W-1:0]   command;
  logic [saws_pkg::TYPE_W-1:0]  packet_type;
  logic [saws_pkg::PSEQ_W-1:0]  packet_seq;

  modport source (output valid, command, packet_type, packet_seq, input ready);
  modport sink   (input valid, command, packet_type, packet_seq, output ready);
endinterface

// ===== rtl/saws_out_if.sv =====
// Result channel of the selective-ack window sender: send requests and done.
// Depends on saws_pkg for field widths.
interface saws_out_if;
  logic                             valid;
  logic                             ready;
  logic [saws_pkg::SEND_SEQ_W-1:0]  send_seq;
  logic                             send_valid;
  logic                             transfer_done;
  logic                             last_of_run;

  modport source (output valid, send_seq, send_valid, transfer_done, last_of_run,
                  input ready);
  modport sink   (input valid, send_seq, send_valid, transfer_done, last_of_run,
                  output ready);
endinterface

// ===== rtl/selective_ack_window_sender.sv =====
// Selective-repeat sender window control, built around one shared adder under a small
// sequencer, with the acknowledged bitmap in a MAX_PACKETS x 1 memory (one port for
// writes, one registered read). Uses saws_pkg, saws_in_if, saws_out_if and the macro
// header. The block takes one command transaction at a time and is not ready until it
// has handed its last result to the output register. A packet or tick is accepted, then
// the round end is checked on the shared adder. A round end sizes the window, then reads
// and tests each window entry in turn (memory read, then test), as the bitmap has a
// single read port, and then releases the final request; results stall in the test
// and release steps when the sink holds off. A start command first clears the bitmap,
// one entry per cycle, before the first round begins; configuration writes are taken
// at any time.
`include "selective_ack_window_sender_macros.svh"

module selective_ack_window_sender #(
  parameter int MAX_PACKETS = saws_pkg::MAX_PACKETS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [saws_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [saws_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  saws_in_if.sink                           item_i,
  saws_out_if.source                        result_o
);

  localparam int AddrW  = $clog2(MAX_PACKETS);
  localparam int LimW   = $clog2(MAX_PACKETS + 1) + 1;
  localparam int TotW   = saws_pkg::TOTAL_W;
  localparam int WinW   = saws_pkg::WIN_W;
  localparam int TimW   = saws_pkg::TIMEOUT_W;
  localparam int AluW   = TotW + 1;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_CLEAR    = 8'b0000_0010,
    ST_EVAL     = 8'b0000_0100,
    ST_ROUND    = 8'b0000_1000,
    ST_SCAN_RD  = 8'b0001_0000,
    ST_SCAN_CHK = 8'b0010_0000,
    ST_FLUSH    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_e;

  // Configuration registers
  logic [WinW-1:0] cfg_win_q;
  logic [TotW-1:0] cfg_total_q;
  logic [TimW-1:0] cfg_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_win_q     <= saws_pkg::WINDOW_SIZE_RST;
      cfg_total_q   <= saws_pkg::TOTAL_PACKETS_RST;
      cfg_timeout_q <= saws_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        saws_pkg::CFG_WINDOW_SIZE:   cfg_win_q     <= cfg_wdata_i[WinW-1:0];
        saws_pkg::CFG_TOTAL_PACKETS: cfg_total_q   <= cfg_wdata_i[TotW-1:0];
        saws_pkg::CFG_TIMEOUT_TICKS: cfg_timeout_q <= cfg_wdata_i[TimW-1:0];
        default: ;
      endcase
    end
  end

  // Effective limits
  logic [WinW-1:0] eff_win;
  logic [TotW-1:0] eff_total;
  logic [AluW-1:0] eff_total_x;
  logic [TimW-1:0] eff_timeout;

  always_comb begin
    if (cfg_win_q == '0) begin
      eff_win = WinW'(1);
    end else if ({1'b0, cfg_win_q} > (WinW + 1)'(saws_pkg::MAX_WINDOW)) begin
      eff_win = WinW'(saws_pkg::MAX_WINDOW);
    end else begin
      eff_win = cfg_win_q;
    end
    if (LimW'(cfg_total_q) > LimW'(MAX_PACKETS)) begin
      eff_total = TotW'(MAX_PACKETS);
    end else begin
      eff_total = cfg_total_q;
    end
    eff_total_x = {1'b0, eff_total};
    eff_timeout = (cfg_timeout_q == '0) ? TimW'(1) : cfg_timeout_q;
  end

  // Sequencer state
  state_e                state_q, state_d;
  logic [TotW-1:0]       next_exp_q, next_exp_d;
  logic [TotW-1:0]       base_q, base_d;
  logic [TimW-1:0]       timer_q, timer_d;
  logic                  running_q, running_d;
  logic [WinW-1:0]       idx_q, idx_d;
  logic [WinW-1:0]       count_q, count_d;
  logic [AddrW-1:0]      clr_q, clr_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [TotW-1:0]       pend_seq_q, pend_seq_d;
  logic [TotW-1:0]       scan_seq_q, scan_seq_d;

  // Output register
  logic                             out_valid_q;
  logic [saws_pkg::SEND_SEQ_W-1:0]  out_seq_q;
  logic                             out_send_q, out_done_q, out_last_q;
  logic                             out_free, out_load;
  logic [TotW-1:0]                  load_seq;
  logic                             load_send, load_done, load_last;

  // Bitmap memory
  logic             mem [MAX_PACKETS];
  logic             mem_we, mem_wdata, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic             rd_q;

  // Shared adder
  logic [AluW-1:0] alu_a, alu_b, alu_y;
  logic            alu_sub;

  logic accept, is_ack, ack_in_range;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign is_ack       = (item_i.packet_type == saws_pkg::PKT_ACK);
  assign ack_in_range = ((saws_pkg::PSEQ_W + 1)'(item_i.packet_seq) <
                         (saws_pkg::PSEQ_W + 1)'(MAX_PACKETS));
  assign out_free     = !out_valid_q || result_o.ready;

  // Select adder operands per step
  always_comb begin
    alu_a   = {1'b0, base_q};
    alu_b   = AluW'(eff_win);
    alu_sub = 1'b0;
    unique case (state_q)
      ST_ROUND: begin
        alu_a   = eff_total_x;
        alu_b   = {1'b0, base_q};
        alu_sub = 1'b1;
      end
      ST_SCAN_RD: begin
        alu_b = AluW'(idx_q);
      end
      default: ;
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    next_exp_d   = next_exp_q;
    base_d       = base_q;
    timer_d      = timer_q;
    running_d    = running_q;
    idx_d        = idx_q;
    count_d      = count_q;
    clr_d        = clr_q;
    pend_valid_d = pend_valid_q;
    pend_seq_d   = pend_seq_q;
    scan_seq_d   = scan_seq_q;
    out_load     = 1'b0;
    load_seq     = pend_seq_q;
    load_send    = 1'b1;
    load_done    = 1'b0;
    load_last    = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = 1'b1;
    mem_waddr    = AddrW'(item_i.packet_seq);
    mem_re       = 1'b0;
    mem_raddr    = AddrW'(alu_y);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (item_i.command)
            saws_pkg::CMD_START: begin
              next_exp_d = '0;
              base_d     = '0;
              running_d  = 1'b1;
              clr_d      = '0;
              state_d    = ST_CLEAR;
            end
            saws_pkg::CMD_PACKET: begin
              if (running_q) begin
                if (is_ack) begin
                  mem_we  = ack_in_range;
                  timer_d = '0;
                end
                if (item_i.packet_seq == saws_pkg::PSEQ_W'(next_exp_q) &&
                    next_exp_q < eff_total) begin
                  next_exp_d = next_exp_q + TotW'(1);
                end
                state_d = ST_EVAL;
              end
            end
            saws_pkg::CMD_TICK: begin
              if (running_q) begin
                if (timer_q != '1) timer_d = timer_q + TimW'(1);
                state_d = ST_EVAL;
              end
            end
            default: ;
          endcase
        end
      end
      // Wipe the bitmap, one entry per cycle
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        mem_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(MAX_PACKETS - 1)) state_d = ST_ROUND;
      end
      // Decide whether the round ends; the adder gives base plus window
      ST_EVAL: begin
        if (timer_q >= eff_timeout || {1'b0, next_exp_q} > alu_y) begin
          if (next_exp_q > base_q) base_d = next_exp_q;
          state_d = ST_ROUND;
        end else begin
          state_d = ST_IDLE;
        end
      end
      // Start a round, or end the transfer once base reaches the total; the adder gives the packets left
      ST_ROUND: begin
        timer_d = '0;
        idx_d   = '0;
        if (base_q >= eff_total) begin
          running_d = 1'b0;
          state_d   = ST_DONE;
        end else begin
          count_d = (alu_y > AluW'(eff_win)) ? eff_win : alu_y[WinW-1:0];
          state_d = ST_SCAN_RD;
        end
      end
      // Read the bitmap at base plus index
      ST_SCAN_RD: begin
        mem_re     = 1'b1;
        scan_seq_d = alu_y[TotW-1:0];
        idx_d      = idx_q + WinW'(1);
        state_d    = ST_SCAN_CHK;
      end
      // Queue an unacknowledged packet, releasing the one held before it
      ST_SCAN_CHK: begin
        if (!rd_q && pend_valid_q && !out_free) begin
          state_d = ST_SCAN_CHK;
        end else begin
          if (!rd_q) begin
            out_load     = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_seq_d   = scan_seq_q;
          end
          state_d = (idx_q == count_q) ? ST_FLUSH : ST_SCAN_RD;
        end
      end
      // Release the held request as the last of the run
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          load_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_seq  = '0;
          load_send = 1'b0;
          load_done = 1'b1;
          load_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      next_exp_q   <= '0;
      base_q       <= '0;
      timer_q      <= '0;
      running_q    <= 1'b0;
      idx_q        <= '0;
      count_q      <= '0;
      clr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_exp_q   <= next_exp_d;
      base_q       <= base_d;
      timer_q      <= timer_d;
      running_q    <= running_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      clr_q        <= clr_d;
      pend_valid_q <= pend_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_seq_q <= pend_seq_d;
    scan_seq_q <= scan_seq_d;
    if (out_load) begin
      out_seq_q  <= load_seq[saws_pkg::SEND_SEQ_W-1:0];
      out_send_q <= load_send;
      out_done_q <= load_done;
      out_last_q <= load_last;
    end
  end

  // Bitmap memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.send_seq      = out_seq_q;
  assign result_o.send_valid    = out_send_q;
  assign result_o.transfer_done = out_done_q;
  assign result_o.last_of_run   = out_last_q;

  // Checks
  `SAWS_ASSERT(a_load_into_free, clk_i, rst_ni, out_load |-> out_free)
  `SAWS_ASSERT_NEVER(a_idle_no_pending, clk_i, rst_ni, (state_q == ST_IDLE) && pend_valid_q)
  `SAWS_ASSERT(a_scan_in_range, clk_i, rst_ni, (state_q == ST_SCAN_RD) |-> (alu_y < eff_total_x))
  `SAWS_ASSERT(a_done_stops, clk_i, rst_ni, (out_load && load_done) |=> !running_q)

endmodule
